/* rtl/session_handshake_fsm_macros.svh */
// Assertion macros shared by the session handshake RTL.
`ifndef SESSION_HANDSHAKE_FSM_MACROS_SVH
`define SESSION_HANDSHAKE_FSM_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SHF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SHF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/shf_pkg.sv */
// Codes, types and widths for the session handshake controller.
`default_nettype none
package shf_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    // event commands
    localparam logic [3:0] CMD_START     = 4'd0;
    localparam logic [3:0] CMD_TRANSPORT = 4'd1;
    localparam logic [3:0] CMD_HELLO     = 4'd2;
    localparam logic [3:0] CMD_SUBMIT    = 4'd3;
    localparam logic [3:0] CMD_POLL      = 4'd4;
    localparam logic [3:0] CMD_TIMEOUT   = 4'd5;
    localparam logic [3:0] CMD_CANCEL    = 4'd6;
    localparam logic [3:0] CMD_CLOSE     = 4'd7;
    localparam logic [3:0] CMD_BIND      = 4'd8;
    localparam logic [3:0] CMD_RECEIVE   = 4'd9;

    // session phases
    localparam logic [3:0] ST_AWAIT_TRANSPORT = 4'd0;
    localparam logic [3:0] ST_AWAIT_HELLO     = 4'd1;
    localparam logic [3:0] ST_AWAIT_INPUT     = 4'd2;
    localparam logic [3:0] ST_PENDING         = 4'd3;
    localparam logic [3:0] ST_ESTABLISHED     = 4'd4;
    localparam logic [3:0] ST_REJECTED        = 4'd5;
    localparam logic [3:0] ST_TIMED_OUT       = 4'd6;
    localparam logic [3:0] ST_CANCELLED       = 4'd7;
    localparam logic [3:0] ST_CLOSED          = 4'd8;

    // actions
    localparam logic [3:0] ACT_NONE          = 4'd0;
    localparam logic [3:0] ACT_CLOSED        = 4'd1;
    localparam logic [3:0] ACT_CANCELLED     = 4'd2;
    localparam logic [3:0] ACT_TIMED_OUT     = 4'd3;
    localparam logic [3:0] ACT_SEND_REJECTED = 4'd4;
    localparam logic [3:0] ACT_SEND_HELLO    = 4'd5;
    localparam logic [3:0] ACT_AUTH_REJECTED = 4'd6;
    localparam logic [3:0] ACT_AUTH_STARTED  = 4'd7;
    localparam logic [3:0] ACT_AUTH_PENDING  = 4'd8;
    localparam logic [3:0] ACT_STALE         = 4'd9;
    localparam logic [3:0] ACT_ESTABLISHED   = 4'd10;

    // errors and stages
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_ILLEGAL  = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW = 2'd2;

    localparam logic [1:0] STG_TRANSPORT  = 2'd0;
    localparam logic [1:0] STG_AUTH_INPUT = 2'd1;
    localparam logic [1:0] STG_PROVIDER   = 2'd2;

    // outcomes
    localparam logic [2:0] OUT_NONE          = 3'd0;
    localparam logic [2:0] OUT_ACCEPTED      = 3'd1;
    localparam logic [2:0] OUT_ILLEGAL       = 3'd2;
    localparam logic [2:0] OUT_AUTH_OK       = 3'd3;
    localparam logic [2:0] OUT_AUTH_REJECTED = 3'd4;
    localparam logic [2:0] OUT_TIMED_OUT     = 3'd5;
    localparam logic [2:0] OUT_CANCELLED     = 3'd6;
    localparam logic [2:0] OUT_STALE         = 3'd7;

    // bind / receive status
    localparam logic [2:0] QRY_NONE            = 3'd0;
    localparam logic [2:0] QRY_BOUND           = 3'd1;
    localparam logic [2:0] QRY_ALREADY         = 3'd2;
    localparam logic [2:0] QRY_NOT_ESTABLISHED = 3'd3;
    localparam logic [2:0] QRY_NOT_BOUND       = 3'd4;
    localparam logic [2:0] QRY_ID_MISMATCH     = 3'd5;
    localparam logic [2:0] QRY_GEN_MISMATCH    = 3'd6;
    localparam logic [2:0] QRY_DELIVERED       = 3'd7;

    // poll verdicts
    localparam logic [1:0] POLL_PENDING  = 2'd0;
    localparam logic [1:0] POLL_ADMITTED = 2'd1;
    localparam logic [1:0] POLL_REJECTED = 2'd2;
    localparam logic [1:0] POLL_RESERVED = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSPORT_TO = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_TO     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROVIDER_TO  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GENERATION   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTEMPT      = 3'd4;

    typedef struct packed {
        logic [31:0] transport_timeout;
        logic [31:0] auth_input_timeout;
        logic [31:0] auth_provider_timeout;
        logic [15:0] session_generation;
        logic [15:0] attempt_id;
    } t_cfg;

    typedef struct packed {
        logic [3:0]  cmd;
        logic [31:0] now_time;
        logic        hello_accepted;
        logic        provider_available;
        logic [1:0]  poll_status;
        logic [15:0] completion_attempt;
        logic [31:0] session_id;
        logic [15:0] op_generation;
    } t_evt;

    typedef struct packed {
        logic [3:0]  phase;
        logic [31:0] deadline;
        logic        deadline_armed;
        logic        auth_busy;
        logic [31:0] bound_id;
        logic        bound_valid;
    } t_sess;

    typedef struct packed {
        logic [3:0] action;
        logic [1:0] error_code;
        logic [1:0] error_stage;
        logic [3:0] session_state;
        logic [2:0] outcome;
        logic [2:0] query_status;
    } t_res;

endpackage
`default_nettype wire

/* rtl/shf_if.sv */
// Event and result channel interfaces of the session handshake controller.
`default_nettype none
interface shf_evt_if;
    logic        valid;
    logic        ready;
    logic [3:0]  cmd;
    logic [31:0] now_time;
    logic        hello_accepted;
    logic        provider_available;
    logic [1:0]  poll_status;
    logic [15:0] completion_attempt;
    logic [31:0] session_id;
    logic [15:0] op_generation;

    modport source (
        output valid, cmd, now_time, hello_accepted, provider_available,
               poll_status, completion_attempt, session_id, op_generation,
        input  ready
    );
    modport sink (
        input  valid, cmd, now_time, hello_accepted, provider_available,
               poll_status, completion_attempt, session_id, op_generation,
        output ready
    );
endinterface

interface shf_res_if;
    logic       valid;
    logic       ready;
    logic [3:0] action;
    logic [1:0] error_code;
    logic [1:0] error_stage;
    logic [3:0] session_state;
    logic [2:0] outcome;
    logic [2:0] query_status;

    modport source (
        output valid, action, error_code, error_stage, session_state, outcome,
               query_status,
        input  ready
    );
    modport sink (
        input  valid, action, error_code, error_stage, session_state, outcome,
               query_status,
        output ready
    );
endinterface
`default_nettype wire

/* rtl/session_handshake_fsm.sv */
// Top level of the session handshake controller: state, config and result registers.
`default_nettype none
`include "session_handshake_fsm_macros.svh"
// Server-side session lifecycle controller. Each beat on i_evt is one event; the block
// decides the transition in the cycle the beat is accepted and presents exactly one result
// beat on o_res in the next cycle. Throughput is one event per clock: the decision is a single
// 33-bit deadline add plus a compare against the stored deadline, and the result register
// frees itself in the same cycle it is taken, so i_evt stays ready while o_res is drained.
// After reset the session rests Closed and all timeouts read zero. Configuration writes on
// i_cfg_* take effect at the next edge and are expected only while no event is in flight.
module session_handshake_fsm (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_we,
    input  wire [shf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [shf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    shf_evt_if.sink                        i_evt,
    shf_res_if.source                      o_res
);
    import shf_pkg::*;

    t_cfg  r_cfg;
    t_sess r_sess;
    t_sess n_sess;
    t_evt  evt;
    t_res  n_res;
    t_res  r_res;
    logic  r_out_valid;
    logic  evt_acc;

    // no beat is taken while reset is held
    assign i_evt.ready = i_rst_n && (!r_out_valid || o_res.ready);
    assign evt_acc     = i_evt.valid && i_evt.ready;

    assign evt.cmd                = i_evt.cmd;
    assign evt.now_time           = i_evt.now_time;
    assign evt.hello_accepted     = i_evt.hello_accepted;
    assign evt.provider_available = i_evt.provider_available;
    assign evt.poll_status        = i_evt.poll_status;
    assign evt.completion_attempt = i_evt.completion_attempt;
    assign evt.session_id         = i_evt.session_id;
    assign evt.op_generation      = i_evt.op_generation;

    shf_step u_step (
        .i_cfg  (r_cfg),
        .i_sess (r_sess),
        .i_evt  (evt),
        .o_sess (n_sess),
        .o_res  (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg              <= '0;
            r_sess.phase       <= ST_CLOSED;
            r_sess.deadline    <= '0;
            r_sess.deadline_armed <= 1'b0;
            r_sess.auth_busy   <= 1'b0;
            r_sess.bound_id    <= '0;
            r_sess.bound_valid <= 1'b0;
            r_out_valid        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_TRANSPORT_TO: r_cfg.transport_timeout     <= i_cfg_data;
                    CFG_INPUT_TO:     r_cfg.auth_input_timeout    <= i_cfg_data;
                    CFG_PROVIDER_TO:  r_cfg.auth_provider_timeout <= i_cfg_data;
                    CFG_GENERATION:   r_cfg.session_generation    <= i_cfg_data[15:0];
                    CFG_ATTEMPT:      r_cfg.attempt_id            <= i_cfg_data[15:0];
                    default: begin
                    end
                endcase
            end
            if (evt_acc) begin
                r_sess      <= n_sess;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (evt_acc) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.action        = r_res.action;
    assign o_res.error_code    = r_res.error_code;
    assign o_res.error_stage   = r_res.error_stage;
    assign o_res.session_state = r_res.session_state;
    assign o_res.outcome       = r_res.outcome;
    assign o_res.query_status  = r_res.query_status;

    `SHF_ASSERT_NEXT(a_accept_loads_result, i_clk, i_rst_n, evt_acc, r_out_valid, "accepted beat produced no result")
    `SHF_ASSERT_NOW(a_result_tracks_phase, i_clk, i_rst_n, r_out_valid, r_res.session_state == r_sess.phase, "held result disagrees with session phase")
    `SHF_ASSERT_NOW(a_busy_only_pending, i_clk, i_rst_n, r_sess.auth_busy, r_sess.phase == ST_PENDING, "auth operation active outside pending")
    `SHF_ASSERT_NOW(a_armed_only_waiting, i_clk, i_rst_n, r_sess.deadline_armed, r_sess.phase < ST_ESTABLISHED, "deadline armed in settled phase")
    `SHF_ASSERT_NOW(a_no_stage_without_error, i_clk, i_rst_n, r_out_valid && r_res.error_code == ERR_NONE, r_res.error_stage == STG_TRANSPORT, "error stage set without error")

endmodule
`default_nettype wire

/* rtl/shf_step.sv */
// Transition logic: one event against the current session, next session and result.
`default_nettype none
module shf_step (
    input  wire shf_pkg::t_cfg  i_cfg,
    input  wire shf_pkg::t_sess i_sess,
    input  wire shf_pkg::t_evt  i_evt,
    output shf_pkg::t_sess o_sess,
    output shf_pkg::t_res  o_res
);
    import shf_pkg::*;

    logic [31:0] dur;
    logic [32:0] sum;
    logic        ovf;
    logic        illegal;
    logic        due;
    logic [1:0]  phase_stage;

    // one adder serves every stage; the command picks the duration
    always_comb begin
        case (i_evt.cmd)
            CMD_HELLO:  dur = i_cfg.auth_input_timeout;
            CMD_SUBMIT: dur = i_cfg.auth_provider_timeout;
            default:    dur = i_cfg.transport_timeout;
        endcase
    end

    assign sum = {1'b0, i_evt.now_time} + {1'b0, dur};
    assign ovf = sum[32];
    assign due = i_sess.deadline_armed && (i_sess.phase < ST_ESTABLISHED)
                 && (i_evt.now_time >= i_sess.deadline);

    always_comb begin
        case (i_sess.phase)
            ST_AWAIT_INPUT: phase_stage = STG_AUTH_INPUT;
            ST_PENDING:     phase_stage = STG_PROVIDER;
            default:        phase_stage = STG_TRANSPORT;
        endcase
    end

    always_comb begin
        o_sess  = i_sess;
        o_res   = '0;
        illegal = 1'b0;
        unique case (i_evt.cmd)
            CMD_START: begin
                if (ovf) begin
                    o_res.error_code  = ERR_OVERFLOW;
                    o_res.error_stage = STG_TRANSPORT;
                end else begin
                    o_sess.phase          = ST_AWAIT_TRANSPORT;
                    o_sess.deadline       = sum[31:0];
                    o_sess.deadline_armed = 1'b1;
                    o_sess.auth_busy      = 1'b0;
                    o_sess.bound_id       = '0;
                    o_sess.bound_valid    = 1'b0;
                end
            end
            CMD_TRANSPORT: begin
                if (i_sess.phase != ST_AWAIT_TRANSPORT) begin
                    illegal = 1'b1;
                end else if (ovf) begin
                    o_res.error_code  = ERR_OVERFLOW;
                    o_res.error_stage = STG_TRANSPORT;
                end else begin
                    o_sess.phase          = ST_AWAIT_HELLO;
                    o_sess.deadline       = sum[31:0];
                    o_sess.deadline_armed = 1'b1;
                    o_res.outcome         = OUT_ACCEPTED;
                end
            end
            CMD_HELLO: begin
                if (i_sess.phase != ST_AWAIT_HELLO) begin
                    illegal = 1'b1;
                end else if (!i_evt.hello_accepted) begin
                    o_sess.phase          = ST_REJECTED;
                    o_sess.deadline_armed = 1'b0;
                    o_res.outcome         = OUT_ACCEPTED;
                    o_res.action          = ACT_SEND_REJECTED;
                end else if (ovf) begin
                    o_res.error_code  = ERR_OVERFLOW;
                    o_res.error_stage = STG_AUTH_INPUT;
                end else begin
                    o_sess.phase          = ST_AWAIT_INPUT;
                    o_sess.deadline       = sum[31:0];
                    o_sess.deadline_armed = 1'b1;
                    o_res.outcome         = OUT_ACCEPTED;
                    o_res.action          = ACT_SEND_HELLO;
                end
            end
            CMD_SUBMIT: begin
                // overflow is checked ahead of the provider verdict
                if (i_sess.phase != ST_AWAIT_INPUT) begin
                    illegal = 1'b1;
                end else if (ovf) begin
                    o_res.error_code  = ERR_OVERFLOW;
                    o_res.error_stage = STG_PROVIDER;
                end else if (!i_evt.provider_available) begin
                    o_sess.phase          = ST_REJECTED;
                    o_sess.deadline_armed = 1'b0;
                    o_res.outcome         = OUT_AUTH_REJECTED;
                    o_res.action          = ACT_AUTH_REJECTED;
                end else begin
                    o_sess.auth_busy      = 1'b1;
                    o_sess.phase          = ST_PENDING;
                    o_sess.deadline       = sum[31:0];
                    o_sess.deadline_armed = 1'b1;
                    o_res.outcome         = OUT_ACCEPTED;
                    o_res.action          = ACT_AUTH_STARTED;
                end
            end
            CMD_POLL: begin
                if (i_sess.phase != ST_PENDING || !i_sess.auth_busy) begin
                    illegal = 1'b1;
                end else if (i_evt.poll_status == POLL_PENDING
                             || i_evt.poll_status == POLL_RESERVED) begin
                    o_res.action = ACT_AUTH_PENDING;
                end else if (i_evt.completion_attempt != i_cfg.attempt_id) begin
                    o_res.outcome = OUT_STALE;
                    o_res.action  = ACT_STALE;
                end else begin
                    o_sess.auth_busy      = 1'b0;
                    o_sess.deadline_armed = 1'b0;
                    if (i_evt.poll_status == POLL_ADMITTED) begin
                        o_sess.phase  = ST_ESTABLISHED;
                        o_res.outcome = OUT_AUTH_OK;
                        o_res.action  = ACT_ESTABLISHED;
                    end else begin
                        o_sess.phase  = ST_REJECTED;
                        o_res.outcome = OUT_AUTH_REJECTED;
                        o_res.action  = ACT_AUTH_REJECTED;
                    end
                end
            end
            CMD_TIMEOUT: begin
                if (due) begin
                    o_sess.auth_busy      = 1'b0;
                    o_sess.phase          = ST_TIMED_OUT;
                    o_sess.deadline_armed = 1'b0;
                    o_res.outcome         = OUT_TIMED_OUT;
                    o_res.action          = ACT_TIMED_OUT;
                end
            end
            CMD_CANCEL: begin
                if (!(i_sess.phase inside {ST_CANCELLED, ST_REJECTED,
                                           ST_TIMED_OUT, ST_CLOSED})) begin
                    o_sess.auth_busy      = 1'b0;
                    o_sess.phase          = ST_CANCELLED;
                    o_sess.deadline_armed = 1'b0;
                    o_res.outcome         = OUT_CANCELLED;
                    o_res.action          = ACT_CANCELLED;
                end
            end
            CMD_CLOSE: begin
                if (i_sess.phase != ST_CLOSED) begin
                    o_sess.auth_busy      = 1'b0;
                    o_sess.phase          = ST_CLOSED;
                    o_sess.deadline_armed = 1'b0;
                    o_res.outcome         = OUT_ACCEPTED;
                    o_res.action          = ACT_CLOSED;
                end
            end
            CMD_BIND: begin
                if (i_sess.phase != ST_ESTABLISHED) begin
                    o_res.query_status = QRY_NOT_ESTABLISHED;
                end else if (i_sess.bound_valid) begin
                    o_res.query_status = QRY_ALREADY;
                end else begin
                    o_sess.bound_id    = i_evt.session_id;
                    o_sess.bound_valid = 1'b1;
                    o_res.query_status = QRY_BOUND;
                end
            end
            CMD_RECEIVE: begin
                if (i_sess.phase != ST_ESTABLISHED) begin
                    o_res.query_status = QRY_NOT_ESTABLISHED;
                end else if (!i_sess.bound_valid) begin
                    o_res.query_status = QRY_NOT_BOUND;
                end else if (i_evt.session_id != i_sess.bound_id) begin
                    o_res.query_status = QRY_ID_MISMATCH;
                end else if (i_evt.op_generation != i_cfg.session_generation) begin
                    o_res.query_status = QRY_GEN_MISMATCH;
                end else begin
                    o_res.query_status = QRY_DELIVERED;
                end
            end
            default: begin
                illegal = 1'b1;
            end
        endcase

        if (illegal) begin
            o_res.action      = ACT_NONE;
            o_res.error_code  = ERR_ILLEGAL;
            o_res.error_stage = phase_stage;
            o_res.outcome     = OUT_ILLEGAL;
        end
        o_res.session_state = o_sess.phase;
    end
endmodule
`default_nettype wire
